[design/fct_pkg.sv]
// Shared types, widths and register codes of the frustum cull test block.
package fct_pkg;

  localparam int CoordWidth = 16;
  localparam int HalfWidth  = CoordWidth - 1;
  localparam int CoefWidth  = 16;
  localparam int NumPlanes  = 6;
  localparam int PlaneWidth = 4 * CoefWidth;
  localparam int CfgIdxWidth = 3;

  // Products of a coefficient with a coordinate or with a half-size.
  localparam int ProdCWidth = CoefWidth + CoordWidth;
  localparam int ProdHWidth = CoefWidth + HalfWidth;
  // Seven terms, each below 2^(ProdCWidth-1) in magnitude, plus headroom.
  localparam int SumWidth   = ProdCWidth + 4;
  // d is scaled by 2^8 and the sphere radius by 2^12 to line up with the products.
  localparam int DShift     = 8;
  localparam int RShift     = 12;

  localparam logic [CfgIdxWidth-1:0] PlaneNear   = 3'd0;
  localparam logic [CfgIdxWidth-1:0] PlaneFar    = 3'd1;
  localparam logic [CfgIdxWidth-1:0] PlaneLeft   = 3'd2;
  localparam logic [CfgIdxWidth-1:0] PlaneRight  = 3'd3;
  localparam logic [CfgIdxWidth-1:0] PlaneTop    = 3'd4;
  localparam logic [CfgIdxWidth-1:0] PlaneBottom = 3'd5;

  typedef enum logic [1:0] {
    ShapePoint  = 2'd0,
    ShapeSphere = 2'd1,
    ShapeCube   = 2'd2,
    ShapeBox    = 2'd3
  } shape_e;

  typedef struct packed {
    shape_e                       op;
    logic signed [CoordWidth-1:0] cx;
    logic signed [CoordWidth-1:0] cy;
    logic signed [CoordWidth-1:0] cz;
    logic [HalfWidth-1:0]         hx;
    logic [HalfWidth-1:0]         hy;
    logic [HalfWidth-1:0]         hz;
  } fct_item_t;

  typedef logic [NumPlanes-1:0][PlaneWidth-1:0] plane_set_t;

endpackage

[design/frustum_cull_test_unit.sv]
// Top level of the six-plane frustum cull test block.
//
// The six planes are loaded through the write port (cfg_we_i, cfg_idx_i,
// cfg_wdata_i): index 0 near, 1 far, 2 left, 3 right, 4 top, 5 bottom, each
// word packing a, b, c, d as signed Q4.12 from the low end up. Writes to
// other indexes are dropped. Reset clears all planes, so every object is
// visible until planes are loaded.
// A query beat is taken at each clock edge where start is high and busy is
// low; busy never rises, so one query can enter every cycle. The result
// beat appears on visible_o with done_o high for one cycle, after the query
// has passed an input register, the multiply stage, the summing stage,
// the per-plane sign test and the output register that combines the six
// plane results. Queries come out in the order they went in.
// The receiver cannot stall, so no result is ever held back. Reset clears
// the in-flight valid bits; queries in the pipeline at reset are dropped.
module frustum_cull_test_unit
  import fct_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             op_i,
  input  logic [CoordWidth-1:0]  center_x_i,
  input  logic [CoordWidth-1:0]  center_y_i,
  input  logic [CoordWidth-1:0]  center_z_i,
  input  logic [HalfWidth-1:0]   half_x_i,
  input  logic [HalfWidth-1:0]   half_y_i,
  input  logic [HalfWidth-1:0]   half_z_i,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [PlaneWidth-1:0]  cfg_wdata_i,
  output logic                   done_o,
  output logic                   visible_o
);

  plane_set_t planes;

  fct_plane_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .planes_o   (planes)
  );

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Input register. A cube uses its one half-size on all three axes.
  fct_item_t item_q, item_d;

  always_comb begin
    item_d.op = shape_e'(op_i);
    item_d.cx = center_x_i;
    item_d.cy = center_y_i;
    item_d.cz = center_z_i;
    item_d.hx = half_x_i;
    item_d.hy = (shape_e'(op_i) == ShapeCube) ? half_x_i : half_y_i;
    item_d.hz = (shape_e'(op_i) == ShapeCube) ? half_x_i : half_z_i;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  logic [NumPlanes-1:0] pass;

  for (genvar p = 0; p < NumPlanes; p++) begin : g_plane
    fct_plane_unit u_plane (
      .clk_i  (clk_i),
      .plane_i(planes[p]),
      .item_i (item_q),
      .pass_o (pass[p])
    );
  end

  // Valid bits follow the beat through the input register and the three plane stages.
  logic [3:0] vld_q;
  logic       done_q;
  logic       visible_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[2:0], accept};
      done_q <= vld_q[3];
    end
  end

  always_ff @(posedge clk_i) begin
    visible_q <= &pass;
  end

  assign done_o    = done_q;
  assign visible_o = visible_q;

  a_latency_fwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##5 done_o)
    else $error("accepted query did not produce a result five cycles later");

  a_latency_bwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 5))
    else $error("result strobe without a query five cycles earlier");

endmodule

[design/fct_plane_regs.sv]
// Configuration register file holding the six frustum planes.
module fct_plane_regs
  import fct_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [PlaneWidth-1:0]  cfg_wdata_i,
  output plane_set_t             planes_o
);

  plane_set_t planes_q, planes_d;

  always_comb begin
    planes_d = planes_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        PlaneNear:   planes_d[0] = cfg_wdata_i;
        PlaneFar:    planes_d[1] = cfg_wdata_i;
        PlaneLeft:   planes_d[2] = cfg_wdata_i;
        PlaneRight:  planes_d[3] = cfg_wdata_i;
        PlaneTop:    planes_d[4] = cfg_wdata_i;
        PlaneBottom: planes_d[5] = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      planes_q <= '0;
    end else begin
      planes_q <= planes_d;
    end
  end

  assign planes_o = planes_q;

endmodule

[design/fct_plane_unit.sv]
// Three-stage test of one object against one plane.
module fct_plane_unit
  import fct_pkg::*;
(
  input  logic                  clk_i,
  input  logic [PlaneWidth-1:0] plane_i,
  input  fct_item_t             item_i,
  output logic                  pass_o
);

  logic signed [CoefWidth-1:0] coef_a, coef_b, coef_c, coef_d;
  logic [CoefWidth-1:0]        mag_a, mag_b, mag_c;
  logic signed [CoordWidth-1:0] cx, cy, cz;

  assign coef_a = plane_i[CoefWidth-1:0];
  assign coef_b = plane_i[2*CoefWidth-1:CoefWidth];
  assign coef_c = plane_i[3*CoefWidth-1:2*CoefWidth];
  assign coef_d = plane_i[4*CoefWidth-1:3*CoefWidth];
  assign cx = item_i.cx;
  assign cy = item_i.cy;
  assign cz = item_i.cz;

  // Magnitudes as unsigned values; the most negative code maps to 2^15.
  assign mag_a = coef_a[CoefWidth-1] ? (~plane_i[CoefWidth-1:0] + 1'b1)
                                     : plane_i[CoefWidth-1:0];
  assign mag_b = coef_b[CoefWidth-1] ? (~plane_i[2*CoefWidth-1:CoefWidth] + 1'b1)
                                     : plane_i[2*CoefWidth-1:CoefWidth];
  assign mag_c = coef_c[CoefWidth-1] ? (~plane_i[3*CoefWidth-1:2*CoefWidth] + 1'b1)
                                     : plane_i[3*CoefWidth-1:2*CoefWidth];

  // Stage 1: products.
  logic signed [ProdCWidth-1:0]       pa_q, pb_q, pc_q;
  logic [ProdHWidth-1:0]              ha_q, hb_q, hc_q;
  logic signed [CoefWidth+DShift-1:0] dsh_q;
  logic [HalfWidth+RShift-1:0]        rad_q;
  shape_e                             op1_q;

  always_ff @(posedge clk_i) begin
    pa_q  <= coef_a * cx;
    pb_q  <= coef_b * cy;
    pc_q  <= coef_c * cz;
    ha_q  <= mag_a * item_i.hx;
    hb_q  <= mag_b * item_i.hy;
    hc_q  <= mag_c * item_i.hz;
    dsh_q <= {coef_d, {DShift{1'b0}}};
    rad_q <= {item_i.hx, {RShift{1'b0}}};
    op1_q <= item_i.op;
  end

  // Stage 2: center distance and the margin the shape adds to it.
  // The best corner of a box lies at distance + |a|hx + |b|hy + |c|hz.
  logic signed [SumWidth-1:0] dist_q, dist_d;
  logic signed [SumWidth-1:0] margin_q, margin_d;

  always_comb begin
    dist_d = SumWidth'(pa_q) + SumWidth'(pb_q) + SumWidth'(pc_q) + SumWidth'(dsh_q);
    case (op1_q)
      ShapePoint:  margin_d = '0;
      ShapeSphere: margin_d = SumWidth'(rad_q);
      ShapeCube,
      ShapeBox:    margin_d = SumWidth'(ha_q) + SumWidth'(hb_q) + SumWidth'(hc_q);
      default:     margin_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    dist_q   <= dist_d;
    margin_q <= margin_d;
  end

  // Stage 3: sign test.
  logic signed [SumWidth-1:0] total;
  logic                       pass_q;

  assign total = dist_q + margin_q;

  always_ff @(posedge clk_i) begin
    pass_q <= ~total[SumWidth-1];
  end

  assign pass_o = pass_q;

endmodule

[verif/frustum_cull_test_unit_tb.sv]
// Self-checking testbench of the frustum cull test unit: queries against loaded plane sets.
`timescale 1ns / 1ps

module frustum_cull_test_unit_tb
  import fct_pkg::*;
();

  localparam int ClkPeriod     = 10;
  localparam int ResetCycles   = 5;
  localparam int WatchdogLimit = 200;
  localparam int SettleCycles  = 10;
  localparam int NumRandPhases = 5;
  localparam int ItemsPerPhase = 215;
  localparam int MaxGap        = 13;
  localparam int Unit          = 256;   // 1.0 in Q8.8
  localparam int CoefOne       = 4096;  // 1.0 in Q4.12
  localparam logic [CfgIdxWidth-1:0] IdxSpareLo = 3'd6;
  localparam logic [CfgIdxWidth-1:0] IdxSpareHi = 3'd7;

  typedef enum logic [1:0] {
    StepQuery,
    StepWrite,
    StepDrain
  } step_e;

  typedef struct {
    step_e                  kind;
    shape_e                 op;
    logic [CoordWidth-1:0]  cx, cy, cz;
    logic [HalfWidth-1:0]   hx, hy, hz;
    logic [CfgIdxWidth-1:0] idx;
    logic [PlaneWidth-1:0]  data;
    int unsigned            gap;
  } step_t;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   start       = 1'b0;
  logic                   busy;
  logic [1:0]             op_i        = '0;
  logic [CoordWidth-1:0]  center_x_i  = '0;
  logic [CoordWidth-1:0]  center_y_i  = '0;
  logic [CoordWidth-1:0]  center_z_i  = '0;
  logic [HalfWidth-1:0]   half_x_i    = '0;
  logic [HalfWidth-1:0]   half_y_i    = '0;
  logic [HalfWidth-1:0]   half_z_i    = '0;
  logic                   cfg_we_i    = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_idx_i   = '0;
  logic [PlaneWidth-1:0]  cfg_wdata_i = '0;
  logic                   done_o;
  logic                   visible_o;

  step_t                 pending_steps[$];
  bit                    expected_vis[$];
  logic [PlaneWidth-1:0] plane_model [NumPlanes];

  bit          query_taken  = 1'b0;
  bit          stim_done    = 1'b0;
  int unsigned gap_left     = 0;
  int unsigned burst_left   = 0;
  int          stall_cycles = 0;
  int          fail_count   = 0;

  frustum_cull_test_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .op_i        (op_i),
    .center_x_i  (center_x_i),
    .center_y_i  (center_y_i),
    .center_z_i  (center_z_i),
    .half_x_i    (half_x_i),
    .half_y_i    (half_y_i),
    .half_z_i    (half_z_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .done_o      (done_o),
    .visible_o   (visible_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Signed distance in Q.20 of a Q8.8 point from one modeled plane.
  function automatic longint plane_dist(int p, longint x, longint y, longint z);
    logic [PlaneWidth-1:0] w;
    shortint               cf [4];
    w     = plane_model[p];
    cf[0] = w[15:0];
    cf[1] = w[31:16];
    cf[2] = w[47:32];
    cf[3] = w[63:48];
    return longint'(cf[0]) * x + longint'(cf[1]) * y + longint'(cf[2]) * z
         + longint'(cf[3]) * (1 <<< DShift);
  endfunction

  function automatic bit predict_visible(shape_e op, shortint cx, shortint cy, shortint cz,
                                         int hx, int hy, int hz);
    bit     vis, hit;
    int     p, k;
    longint x, y, z;
    vis = 1'b1;
    if (op == ShapeCube) begin
      hy = hx;
      hz = hx;
    end
    for (p = 0; p < NumPlanes; p++) begin
      case (op)
        ShapePoint:  hit = plane_dist(p, cx, cy, cz) >= 0;
        ShapeSphere: hit = plane_dist(p, cx, cy, cz) >= -(longint'(hx) * (1 <<< RShift));
        default: begin
          // A plane passes as soon as any one corner lies on its inner side.
          hit = 1'b0;
          for (k = 0; k < 8; k++) begin
            x = k[0] ? cx + hx : cx - hx;
            y = k[1] ? cy + hy : cy - hy;
            z = k[2] ? cz + hz : cz - hz;
            if (plane_dist(p, x, y, z) >= 0) hit = 1'b1;
          end
        end
      endcase
      vis &= hit;
    end
    return vis;
  endfunction

  function automatic logic [PlaneWidth-1:0] pack_plane(int a, int b, int c, int d);
    return {d[CoefWidth-1:0], c[CoefWidth-1:0], b[CoefWidth-1:0], a[CoefWidth-1:0]};
  endfunction

  task automatic push_query(shape_e op, int cx, int cy, int cz, int hx, int hy, int hz);
    step_t s;
    s.kind = StepQuery;
    s.op   = op;
    s.cx   = CoordWidth'(cx);
    s.cy   = CoordWidth'(cy);
    s.cz   = CoordWidth'(cz);
    s.hx   = HalfWidth'(hx);
    s.hy   = HalfWidth'(hy);
    s.hz   = HalfWidth'(hz);
    s.idx  = '0;
    s.data = '0;
    // Mostly random gaps, with occasional back-to-back stretches.
    if (burst_left != 0) begin
      s.gap = 0;
      burst_left--;
    end else if ($urandom_range(0, 19) == 0) begin
      s.gap      = 0;
      burst_left = $urandom_range(10, 40);
    end else begin
      s.gap = $urandom_range(0, MaxGap);
    end
    pending_steps.push_back(s);
  endtask

  task automatic push_write(logic [CfgIdxWidth-1:0] idx, logic [PlaneWidth-1:0] data);
    step_t s;
    s      = '{kind: StepWrite, op: ShapePoint, default: '0};
    s.idx  = idx;
    s.data = data;
    pending_steps.push_back(s);
  endtask

  task automatic push_drain();
    step_t s;
    s = '{kind: StepDrain, op: ShapePoint, default: '0};
    pending_steps.push_back(s);
  endtask

  // Axis-aligned frustum: each plane keeps one coordinate within its offset.
  task automatic load_box(int d_left, int d_right, int d_bottom, int d_top,
                          int d_near, int d_far);
    push_write(PlaneNear,   pack_plane(0, 0, CoefOne, d_near));
    push_write(PlaneFar,    pack_plane(0, 0, -CoefOne, d_far));
    push_write(PlaneLeft,   pack_plane(CoefOne, 0, 0, d_left));
    push_write(PlaneRight,  pack_plane(-CoefOne, 0, 0, d_right));
    push_write(PlaneTop,    pack_plane(0, -CoefOne, 0, d_top));
    push_write(PlaneBottom, pack_plane(0, CoefOne, 0, d_bottom));
  endtask

  always @(negedge clk_i) begin : drive_blk
    bit    drive_q, drive_w;
    step_t s;
    drive_q = 1'b0;
    drive_w = 1'b0;
    if (rst_ni && !stim_done) begin
      if (start && !query_taken) begin
        drive_q = 1'b1;
      end else if (gap_left != 0) begin
        gap_left--;
      end else if (pending_steps.size() == 0) begin
        stim_done = 1'b1;
      end else begin
        case (pending_steps[0].kind)
          StepQuery: begin
            s = pending_steps.pop_front();
            op_i       <= s.op;
            center_x_i <= s.cx;
            center_y_i <= s.cy;
            center_z_i <= s.cz;
            half_x_i   <= s.hx;
            half_y_i   <= s.hy;
            half_z_i   <= s.hz;
            gap_left = s.gap;
            drive_q  = 1'b1;
          end
          StepWrite: begin
            // Planes change only with nothing in flight.
            if (expected_vis.size() == 0) begin
              s = pending_steps.pop_front();
              cfg_idx_i   <= s.idx;
              cfg_wdata_i <= s.data;
              drive_w = 1'b1;
            end
          end
          default: begin
            if (expected_vis.size() == 0) pending_steps.delete(0);
          end
        endcase
      end
    end
    start    <= drive_q;
    cfg_we_i <= drive_w;
  end

  always @(posedge clk_i) begin : check_blk
    bit want;
    int i;
    query_taken = 1'b0;
    if (!rst_ni) begin
      for (i = 0; i < NumPlanes; i++) plane_model[i] = '0;
    end else begin
      stall_cycles++;
      if (done_o === 1'b1) begin
        stall_cycles = 0;
        if (expected_vis.size() == 0) begin
          $error("visible: expected none, actual %0b", visible_o);
          fail_count++;
        end else begin
          want = expected_vis.pop_front();
          if (visible_o !== want) begin
            $error("visible: expected %0b, actual %0b", want, visible_o);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        expected_vis.push_back(predict_visible(shape_e'(op_i), center_x_i, center_y_i,
                                               center_z_i, half_x_i, half_y_i, half_z_i));
        query_taken  = 1'b1;
        stall_cycles = 0;
      end
      if (cfg_we_i) begin
        stall_cycles = 0;
        if (cfg_idx_i < NumPlanes) plane_model[cfg_idx_i] = cfg_wdata_i;
      end
    end
  end

  initial begin : main_blk
    int                    phase, n, i;
    shape_e                rop;
    bit                    wide;
    logic [CoordWidth-1:0] rc [3];
    logic [HalfWidth-1:0]  rh [3];
    logic [PlaneWidth-1:0] w;

    // Planes cleared by reset: everything is visible, and spare indexes do nothing.
    push_write(IdxSpareLo, '1);
    push_write(IdxSpareHi, {4{16'h8000}});
    push_query(ShapePoint, -32768, -32768, -32768, 0, 0, 0);
    push_query(ShapeSphere, 32767, 32767, 32767, 32767, 32767, 32767);
    push_query(ShapeCube, -32768, 32767, 0, 32767, 0, 0);
    push_query(ShapeBox, 32767, -32768, -1, 32767, 0, 32767);

    // Box of four units each way; most items sit exactly on or just past a face.
    load_box(4 * CoefOne, 4 * CoefOne, 4 * CoefOne, 4 * CoefOne, 4 * CoefOne, 4 * CoefOne);
    push_query(ShapePoint, 0, 0, 0, 0, 0, 0);
    push_query(ShapePoint, 4 * Unit, 0, 0, 0, 0, 0);
    push_query(ShapePoint, 4 * Unit + 1, 0, 0, 0, 0, 0);
    push_query(ShapePoint, 5 * Unit, 0, 0, 32767, 32767, 32767);
    push_query(ShapeSphere, 5 * Unit, 0, 0, Unit, 32767, 32767);
    push_query(ShapeSphere, 5 * Unit, 0, 0, Unit - 1, 0, 0);
    push_query(ShapeCube, 5 * Unit, 0, 0, Unit, 0, 0);
    push_query(ShapeCube, 5 * Unit, 0, 0, Unit - 1, 32767, 32767);
    push_query(ShapeBox, 0, 0, 6 * Unit, 0, 0, 2 * Unit);
    push_query(ShapeBox, 0, 0, 6 * Unit, 0, 0, 2 * Unit - 1);

    // Largest and most negative coefficients on every plane.
    for (i = 0; i < NumPlanes; i++) push_write(CfgIdxWidth'(i), {4{16'h7FFF}});
    push_query(ShapePoint, -32768, -32768, -32768, 0, 0, 0);
    push_query(ShapeBox, 32767, 32767, 32767, 32767, 32767, 32767);
    push_query(ShapeSphere, 0, 0, 0, 0, 0, 0);
    for (i = 0; i < NumPlanes; i++) push_write(CfgIdxWidth'(i), {4{16'h8000}});
    push_query(ShapePoint, -32768, -32768, -32768, 0, 0, 0);
    push_query(ShapeCube, 32767, 32767, 32767, 32767, 0, 0);
    push_query(ShapeBox, -1, -1, -1, 32767, 32767, 32767);

    for (phase = 0; phase < NumRandPhases; phase++) begin
      case (phase)
        1: begin
          for (i = 0; i < NumPlanes; i++) push_write(CfgIdxWidth'(i), {$urandom, $urandom});
        end
        2: begin
          for (i = 0; i < NumPlanes; i++) begin
            push_write(CfgIdxWidth'(i),
                       pack_plane($urandom_range(0, 2 * CoefOne) - CoefOne,
                                  $urandom_range(0, 2 * CoefOne) - CoefOne,
                                  $urandom_range(0, 2 * CoefOne) - CoefOne,
                                  $urandom_range(0, 65535) - 32768));
          end
        end
        3: begin
          for (i = 0; i < NumPlanes; i++) begin
            case ($urandom_range(0, 4))
              0:       w = '0;
              1:       w = '1;
              2:       w = {4{16'h7FFF}};
              3:       w = {4{16'h8000}};
              default: w = {$urandom, $urandom};
            endcase
            push_write(CfgIdxWidth'(i), w);
          end
        end
        default: begin
          load_box($urandom_range(Unit, 32767), $urandom_range(Unit, 32767),
                   $urandom_range(Unit, 32767), $urandom_range(Unit, 32767),
                   $urandom_range(Unit, 32767), $urandom_range(Unit, 32767));
        end
      endcase
      if ($urandom_range(0, 1) == 0) push_write(IdxSpareLo, {$urandom, $urandom});
      else push_write(IdxSpareHi, {$urandom, $urandom});

      for (n = 0; n < ItemsPerPhase; n++) begin
        // The sender also holds off now and then until the pipeline is empty.
        if (n == ItemsPerPhase / 2 || $urandom_range(0, 59) == 0) push_drain();
        rop  = shape_e'($urandom_range(0, 3));
        wide = ($urandom_range(0, 4) == 0);
        for (i = 0; i < 3; i++) begin
          rc[i] = CoordWidth'(wide ? $urandom : $urandom_range(0, 12 * Unit) - 6 * Unit);
          case ($urandom_range(0, 9))
            0:       rh[i] = '0;
            1:       rh[i] = HalfWidth'($urandom);
            default: rh[i] = HalfWidth'($urandom_range(0, 2 * Unit));
          endcase
        end
        push_query(rop, rc[0], rc[1], rc[2], rh[0], rh[1], rh[2]);
      end
    end

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (!(stim_done && expected_vis.size() == 0) && stall_cycles < WatchdogLimit)
      @(negedge clk_i);
    if (stall_cycles < WatchdogLimit) repeat (SettleCycles) @(negedge clk_i);

    if (stall_cycles < WatchdogLimit && fail_count == 0 && expected_vis.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
